FILE: rtl/cdb_key_lookup_engine_macros.svh
// Assertion helpers for the cdb lookup engine.
`ifndef CDB_KEY_LOOKUP_ENGINE_MACROS_SVH
`define CDB_KEY_LOOKUP_ENGINE_MACROS_SVH

// Same-cycle implication, held off during reset.
`define CKLE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ckle assertion failed");

// Next-cycle implication, held off during reset.
`define CKLE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ckle assertion failed");

`endif

FILE: rtl/ckle_pkg.sv
// ----------------------------------------------------------------------------
// ckle_pkg
// Request and status codes for the cdb key lookup engine.
// ----------------------------------------------------------------------------
package ckle_pkg;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_READ  = 2'd1,
        REQ_KEY   = 2'd2,
        REQ_NEXT  = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FOUND    = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_TOOLONG  = 3'd3,
        ST_RANGE    = 3'd4
    } t_status;

    localparam logic [31:0] HASH_INIT = 32'd5381;

endpackage

FILE: rtl/cdb_key_lookup_engine.sv
// Write and key-byte replies are registered; a read passes through S_RD first. A lookup
// fetches 32-bit words byte by byte: the header, a slot-start modulo, then per probe the
// slot; on a hash match the record header, a compare per key byte and a final check.
// One request at a time; busy is high whenever the engine is not idle.
// All image reads and writes go through the single byte-wide image port. Reset (synchronous, active low)
// clears control state only; results are strobed for one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
// cdb_key_lookup_engine
// Constant-database lookup: image loading, djb key hashing, linear probing.
// ----------------------------------------------------------------------------
`include "cdb_key_lookup_engine_macros.svh"

module cdb_key_lookup_engine
    import ckle_pkg::*;
#(
    parameter int IMAGE_BYTES   = 65536,
    parameter int MAX_KEY_BYTES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_req_type,
    input  logic [15:0] i_mem_addr,
    input  logic [7:0]  i_wr_byte,
    input  logic [7:0]  i_key_byte,
    input  logic        i_key_last,
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic [7:0]  o_rd_byte,
    output logic [15:0] o_value_addr,
    output logic [15:0] o_value_len
);

    localparam int AW   = $clog2(IMAGE_BYTES);
    localparam int KIW  = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam int KCW  = $clog2(MAX_KEY_BYTES + 2);   // holds MAX + 1
    localparam int CIW  = $clog2(MAX_KEY_BYTES + 1);   // holds MAX
    localparam logic [34:0] LIM     = 35'(IMAGE_BYTES);
    localparam logic [KCW-1:0] KMAX = KCW'(MAX_KEY_BYTES);

    typedef enum logic [2:0] {
        S_IDLE, S_RD, S_FETCH, S_DIV, S_PROBE, S_CMP_RD, S_CMP_CK, S_FINAL
    } t_state;

    // which 32-bit word a fetch is after
    typedef enum logic [2:0] {
        PH_HDR_BASE, PH_HDR_CNT, PH_SLOT_HV, PH_SLOT_POS, PH_KLEN, PH_DLEN
    } t_phase;

    // memories
    logic [7:0] image_mem [IMAGE_BYTES];
    logic [7:0] key_mem   [MAX_KEY_BYTES];
    logic [7:0] r_mem_q;
    logic [7:0] r_key_q;

    // control
    t_state         r_state;
    t_phase         r_phase;
    logic [AW-1:0]  r_faddr;
    logic [2:0]     r_fcnt;
    logic [31:0]    r_word;
    logic [KCW-1:0] r_key_count;
    logic [31:0]    r_hash;
    logic [31:0]    r_want_hash;
    logic [CIW-1:0] r_want_len;
    logic [31:0]    r_tbase;
    logic [31:0]    r_stotal;
    logic [31:0]    r_slot;
    logic [31:0]    r_pdone;
    logic           r_open;
    logic [31:0]    r_hv;
    logic [31:0]    r_pos;
    logic [31:0]    r_klen;
    logic [31:0]    r_dlen;
    logic [34:0]    r_data;
    logic [CIW-1:0] r_ci;
    logic [31:0]    r_rem;
    logic [23:0]    r_dvd;
    logic [4:0]     r_dcnt;

    // results
    logic           r_valid;
    t_status        r_status;
    logic [7:0]     r_rd_byte;
    logic [15:0]    r_vaddr;
    logic [15:0]    r_vlen;

    logic           w_accept;
    logic           w_in_range;
    logic [31:0]    w_maddr;
    logic [31:0]    w_hash_n;
    logic [31:0]    w_word;
    logic [AW-1:0]  w_raddr;
    logic [35:0]    w_sa;
    logic [31:0]    w_slot_n;
    logic [32:0]    w_trial;
    logic [34:0]    w_end;

    assign w_accept   = start && !busy;
    assign w_maddr    = 32'(i_mem_addr);
    assign w_in_range = 35'(w_maddr) < LIM;
    assign w_hash_n   = ((r_hash << 5) + r_hash) ^ 32'(i_key_byte);
    assign w_word     = {r_mem_q, r_word[31:8]};
    // base + slot * 8 can pass 2^35, so one spare bit
    assign w_sa       = 36'(r_tbase) + {1'b0, r_slot, 3'b000};
    assign w_slot_n   = (r_slot + 32'd1 == r_stotal) ? 32'd0 : r_slot + 32'd1;
    assign w_trial    = {r_rem, r_dvd[23]};
    assign w_end      = r_data + 35'(r_dlen);

    // image read address: host read, word fetch or key compare
    always_comb begin
        unique case (r_state)
            S_FETCH:  w_raddr = r_faddr + AW'(r_fcnt);
            S_CMP_RD: w_raddr = r_pos[AW-1:0] + AW'(8) + AW'(r_ci);
            default:  w_raddr = w_maddr[AW-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_req_type == REQ_WRITE && w_in_range) begin
            image_mem[w_maddr[AW-1:0]] <= i_wr_byte;
        end
        r_mem_q <= image_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_req_type == REQ_KEY && r_key_count < KMAX) begin
            key_mem[r_key_count[KIW-1:0]] <= i_key_byte;
        end
        r_key_q <= key_mem[r_ci[KIW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_HDR_BASE;
            r_fcnt      <= '0;
            r_key_count <= '0;
            r_hash      <= HASH_INIT;
            r_want_hash <= '0;
            r_want_len  <= '0;
            r_tbase     <= '0;
            r_stotal    <= '0;
            r_slot      <= '0;
            r_pdone     <= '0;
            r_open      <= 1'b0;
            r_ci        <= '0;
            r_dcnt      <= '0;
            r_valid     <= 1'b0;
            r_status    <= ST_OK;
            r_rd_byte   <= '0;
            r_vaddr     <= '0;
            r_vlen      <= '0;
        end else begin
            r_valid   <= 1'b0;
            r_rd_byte <= '0;
            r_vaddr   <= '0;
            r_vlen    <= '0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        unique case (t_req'(i_req_type))
                            REQ_WRITE: begin
                                r_valid  <= 1'b1;
                                r_status <= w_in_range ? ST_OK : ST_RANGE;
                            end
                            REQ_READ: begin
                                if (w_in_range) begin
                                    r_state <= S_RD;
                                end else begin
                                    r_valid  <= 1'b1;
                                    r_status <= ST_RANGE;
                                end
                            end
                            REQ_KEY: begin
                                r_open <= 1'b0;
                                if (!i_key_last) begin
                                    r_valid <= 1'b1;
                                    if (r_key_count < KMAX) begin
                                        r_key_count <= r_key_count + KCW'(1);
                                        r_hash      <= w_hash_n;
                                        r_status    <= ST_OK;
                                    end else begin
                                        r_key_count <= KMAX + KCW'(1);
                                        r_status    <= ST_TOOLONG;
                                    end
                                end else begin
                                    r_key_count <= '0;
                                    r_hash      <= HASH_INIT;
                                    if (r_key_count >= KMAX) begin
                                        r_valid  <= 1'b1;
                                        r_status <= ST_TOOLONG;
                                    end else begin
                                        // final byte: latch key, fetch header slot
                                        r_want_hash <= w_hash_n;
                                        r_want_len  <= CIW'(r_key_count + KCW'(1));
                                        r_faddr     <= AW'({w_hash_n[7:0], 3'b000});
                                        r_fcnt      <= '0;
                                        r_phase     <= PH_HDR_BASE;
                                        r_state     <= S_FETCH;
                                    end
                                end
                            end
                            REQ_NEXT: begin
                                if (r_open) begin
                                    r_state <= S_PROBE;
                                end else begin
                                    r_valid  <= 1'b1;
                                    r_status <= ST_NOTFOUND;
                                end
                            end
                        endcase
                    end
                end

                S_RD: begin
                    r_valid   <= 1'b1;
                    r_status  <= ST_OK;
                    r_rd_byte <= r_mem_q;
                    r_state   <= S_IDLE;
                end

                S_FETCH: begin
                    r_fcnt <= r_fcnt + 3'd1;
                    if (r_fcnt != 3'd0) begin
                        r_word <= w_word;
                    end
                    if (r_fcnt == 3'd4) begin
                        r_fcnt <= '0;
                        unique case (r_phase)
                            PH_HDR_BASE: begin
                                r_tbase <= w_word;
                                r_faddr <= r_faddr + AW'(4);
                                r_phase <= PH_HDR_CNT;
                            end
                            PH_HDR_CNT: begin
                                r_stotal <= w_word;
                                r_pdone  <= '0;
                                if (w_word == 32'd0) begin
                                    r_slot   <= '0;
                                    r_open   <= 1'b0;
                                    r_valid  <= 1'b1;
                                    r_status <= ST_NOTFOUND;
                                    r_state  <= S_IDLE;
                                end else begin
                                    r_rem   <= '0;
                                    r_dvd   <= r_want_hash[31:8];
                                    r_dcnt  <= 5'd24;
                                    r_state <= S_DIV;
                                end
                            end
                            PH_SLOT_HV: begin
                                r_hv    <= w_word;
                                r_faddr <= r_faddr + AW'(4);
                                r_phase <= PH_SLOT_POS;
                            end
                            PH_SLOT_POS: begin
                                if (w_word == 32'd0) begin
                                    r_open   <= 1'b0;
                                    r_valid  <= 1'b1;
                                    r_status <= ST_NOTFOUND;
                                    r_state  <= S_IDLE;
                                end else if (r_hv != r_want_hash) begin
                                    r_state <= S_PROBE;
                                end else if (35'(w_word) + 35'd8 > LIM) begin
                                    r_open   <= 1'b0;
                                    r_valid  <= 1'b1;
                                    r_status <= ST_RANGE;
                                    r_state  <= S_IDLE;
                                end else begin
                                    r_pos   <= w_word;
                                    r_faddr <= w_word[AW-1:0];
                                    r_phase <= PH_KLEN;
                                end
                            end
                            PH_KLEN: begin
                                r_klen  <= w_word;
                                r_faddr <= r_faddr + AW'(4);
                                r_phase <= PH_DLEN;
                            end
                            PH_DLEN: begin
                                r_dlen <= w_word;
                                r_data <= 35'(r_pos) + 35'd8 + 35'(r_klen);
                                if (r_klen != 32'(r_want_len)) begin
                                    r_state <= S_PROBE;
                                end else if (35'(r_pos) + 35'd8 + 35'(r_klen) > LIM) begin
                                    r_open   <= 1'b0;
                                    r_valid  <= 1'b1;
                                    r_status <= ST_RANGE;
                                    r_state  <= S_IDLE;
                                end else begin
                                    r_ci    <= '0;
                                    r_state <= S_CMP_RD;
                                end
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end

                // restoring remainder, one quotient bit per cycle
                S_DIV: begin
                    r_dvd  <= {r_dvd[22:0], 1'b0};
                    r_dcnt <= r_dcnt - 5'd1;
                    if (w_trial >= {1'b0, r_stotal}) begin
                        r_rem <= 32'(w_trial - {1'b0, r_stotal});
                    end else begin
                        r_rem <= w_trial[31:0];
                    end
                    if (r_dcnt == 5'd1) begin
                        r_slot  <= (w_trial >= {1'b0, r_stotal})
                                   ? 32'(w_trial - {1'b0, r_stotal}) : w_trial[31:0];
                        r_open  <= 1'b1;
                        r_state <= S_PROBE;
                    end
                end

                S_PROBE: begin
                    if (r_pdone >= r_stotal) begin
                        r_open   <= 1'b0;
                        r_valid  <= 1'b1;
                        r_status <= ST_NOTFOUND;
                        r_state  <= S_IDLE;
                    end else begin
                        r_slot  <= w_slot_n;
                        r_pdone <= r_pdone + 32'd1;
                        if (w_sa + 36'd8 > 36'(LIM)) begin
                            r_open   <= 1'b0;
                            r_valid  <= 1'b1;
                            r_status <= ST_RANGE;
                            r_state  <= S_IDLE;
                        end else begin
                            r_faddr <= w_sa[AW-1:0];
                            r_fcnt  <= '0;
                            r_phase <= PH_SLOT_HV;
                            r_state <= S_FETCH;
                        end
                    end
                end

                S_CMP_RD: begin
                    if (r_ci == r_want_len) begin
                        r_state <= S_FINAL;
                    end else begin
                        r_state <= S_CMP_CK;
                    end
                end

                S_CMP_CK: begin
                    if (r_mem_q != r_key_q) begin
                        r_state <= S_PROBE;
                    end else begin
                        r_ci    <= r_ci + CIW'(1);
                        r_state <= S_CMP_RD;
                    end
                end

                S_FINAL: begin
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                    if (w_end > LIM || r_data > 35'h0FFFF || r_dlen > 32'h0000FFFF) begin
                        r_open   <= 1'b0;
                        r_status <= ST_RANGE;
                    end else begin
                        r_status <= ST_FOUND;
                        r_vaddr  <= r_data[15:0];
                        r_vlen   <= r_dlen[15:0];
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy         = (r_state != S_IDLE);
    assign o_valid      = r_valid;
    assign o_status     = r_status;
    assign o_rd_byte    = r_rd_byte;
    assign o_value_addr = r_vaddr;
    assign o_value_len  = r_vlen;

    `CKLE_ASSERT_IMP(a_found_keeps_open, i_clk, i_rst_n, o_valid && o_status == ST_FOUND, r_open)
    `CKLE_ASSERT_IMP(a_no_value_unless_found, i_clk, i_rst_n, o_valid && o_status != ST_FOUND,
                     o_value_addr == 16'd0 && o_value_len == 16'd0)
    `CKLE_ASSERT_NXT(a_read_goes_busy, i_clk, i_rst_n,
                     w_accept && i_req_type == REQ_READ && w_in_range, busy && !o_valid)
    `CKLE_ASSERT_IMP(a_no_result_in_fetch, i_clk, i_rst_n, r_state == S_FETCH && r_fcnt != 3'd0,
                     !o_valid)

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for cdb_key_lookup_engine. It loads a small cdb image
// into the engine, looks its keys up, walks duplicate matches with next
// requests, damages some headers and records to hit the error paths, and
// then runs mixed random traffic. A behavioral model predicts every reply,
// and the replies are checked in order.
// ----------------------------------------------------------------------------
module testbench;
    import ckle_pkg::*;

    localparam int IMG   = 65536;
    localparam int KMAX  = 64;
    localparam int NKEYS = 8;

    typedef struct packed {
        t_status     status;
        logic [7:0]  rd_byte;
        logic [15:0] value_addr;
        logic [15:0] value_len;
    } t_reply;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_req_type;
    logic [15:0] i_mem_addr;
    logic [7:0]  i_wr_byte;
    logic [7:0]  i_key_byte;
    logic        i_key_last;
    logic        o_valid;
    logic [2:0]  o_status;
    logic [7:0]  o_rd_byte;
    logic [15:0] o_value_addr;
    logic [15:0] o_value_len;

    cdb_key_lookup_engine DUT (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Behavioral copy of the engine state
    // ------------------------------------------------------------------
    logic [7:0]  img_shadow [IMG];
    logic [7:0]  key_shadow [KMAX];
    int unsigned key_fill;
    logic [31:0] hash_acc;
    logic [31:0] tbl_base, tbl_slots, cur_slot, slots_seen;
    bit          search_live;
    logic [31:0] target_hash, target_len;

    // written image addresses, so reads never touch unwritten bytes
    bit          img_written [IMG];
    int          written_addrs [$];

    t_reply      pending_replies [$];
    int          mismatches;
    int          replies_seen;
    int          status_count [8];

    int          gap_pct;
    int          hold_gap;

    // key database built by the bench
    logic [7:0]  db_key [NKEYS][KMAX];
    int          db_len [NKEYS];
    logic [31:0] db_hash [NKEYS];
    int          rec_at [NKEYS];
    int          data_addrs [$];
    bit          bucket_used [256];   // header slot written, safe to look up
    int          heap_ptr;

    logic [7:0]  kbytes [72];

    function automatic logic [31:0] img_word(longint a);
        return {img_shadow[a + 3], img_shadow[a + 2], img_shadow[a + 1], img_shadow[a]};
    endfunction

    function automatic logic [31:0] djb_hash(int n);
        logic [31:0] h;
        h = HASH_INIT;
        for (int i = 0; i < n; i++) h = (h * 33) ^ {24'd0, kbytes[i]};
        return h;
    endfunction

    // Resume the linear probe from the saved slot position.
    task automatic walk_slots(inout t_reply r);
        longint sa, pos, data;
        logic [31:0] hv, klen, dlen;
        int i;
        if (!search_live) begin
            r.status = ST_NOTFOUND;
            return;
        end
        while (slots_seen < tbl_slots) begin
            sa = longint'(tbl_base) + longint'(cur_slot) * 8;
            cur_slot = (longint'(cur_slot) + 1) % longint'(tbl_slots);
            slots_seen++;
            if (sa + 8 > IMG) begin
                search_live = 0; r.status = ST_RANGE; return;
            end
            hv  = img_word(sa);
            pos = img_word(sa + 4);
            if (pos == 0) begin
                search_live = 0; r.status = ST_NOTFOUND; return;
            end
            if (hv != target_hash) continue;
            if (pos + 8 > IMG) begin
                search_live = 0; r.status = ST_RANGE; return;
            end
            klen = img_word(pos);
            dlen = img_word(pos + 4);
            if (klen != target_len) continue;
            data = pos + 8 + klen;
            if (data > IMG) begin
                search_live = 0; r.status = ST_RANGE; return;
            end
            for (i = 0; i < klen; i++)
                if (img_shadow[pos + 8 + i] != key_shadow[i]) break;
            if (i < klen) continue;
            if (data + dlen > IMG || data > 'hFFFF || dlen > 'hFFFF) begin
                search_live = 0; r.status = ST_RANGE; return;
            end
            r.status     = ST_FOUND;
            r.value_addr = data[15:0];
            r.value_len  = dlen[15:0];
            return;
        end
        search_live = 0;
        r.status = ST_NOTFOUND;
    endtask

    task automatic predict_reply(t_req rq, logic [15:0] a, logic [7:0] wb,
                                 logic [7:0] kb, logic kl, output t_reply r);
        logic [31:0] hdr;
        bit too_long;
        r = '{ST_OK, 8'd0, 16'd0, 16'd0};
        case (rq)
            REQ_WRITE: img_shadow[a] = wb;     // 16-bit address never exceeds image
            REQ_READ:  r.rd_byte = img_shadow[a];
            REQ_KEY: begin
                search_live = 0;
                if (key_fill < KMAX) begin
                    key_shadow[key_fill] = kb;
                    key_fill++;
                    hash_acc = (hash_acc * 33) ^ {24'd0, kb};
                end else begin
                    key_fill = KMAX + 1;
                    r.status = ST_TOOLONG;
                end
                if (kl) begin
                    too_long = key_fill > KMAX;
                    if (!too_long) begin
                        target_hash = hash_acc;
                        target_len  = key_fill;
                    end
                    key_fill = 0;
                    hash_acc = HASH_INIT;
                    if (too_long) r.status = ST_TOOLONG;
                    else begin
                        hdr = (target_hash % 256) * 8;
                        tbl_base   = img_word(hdr);
                        tbl_slots  = img_word(hdr + 4);
                        slots_seen = 0;
                        if (tbl_slots == 0) begin
                            cur_slot = 0;
                            search_live = 0;
                            r.status = ST_NOTFOUND;
                        end else begin
                            cur_slot = (target_hash / 256) % tbl_slots;
                            search_live = 1;
                            walk_slots(r);
                        end
                    end
                end
            end
            default: walk_slots(r);
        endcase
    endtask

    // ------------------------------------------------------------------
    // One transfer: wait out the sender gap, hold start until accepted
    // ------------------------------------------------------------------
    task automatic issue(t_req rq, logic [15:0] a, logic [7:0] wb, logic [7:0] kb, logic kl);
        bit ok;
        t_reply r;
        repeat (hold_gap) @(posedge i_clk);
        start      <= 1'b1;
        i_req_type <= rq;
        i_mem_addr <= a;
        i_wr_byte  <= wb;
        i_key_byte <= kb;
        i_key_last <= kl;
        do begin
            @(negedge i_clk);
            ok = !busy;
            @(posedge i_clk);
        end while (!ok);
        predict_reply(rq, a, wb, kb, kl, r);
        pending_replies.push_back(r);
        if (rq == REQ_WRITE && !img_written[a]) begin
            img_written[a] = 1;
            written_addrs.push_back(a);
        end
        // decide the next gap now so start is dropped at most once per edge
        hold_gap = ($urandom_range(99) < gap_pct) ? $urandom_range(1, 6) : 0;
        if (hold_gap != 0) start <= 1'b0;
    endtask

    task automatic put8(int a, logic [7:0] v);
        issue(REQ_WRITE, a[15:0], v, 8'($urandom), 1'($urandom));
    endtask

    task automatic put32(int a, logic [31:0] v);
        for (int i = 0; i < 4; i++) put8(a + i, v[8*i +: 8]);
    endtask

    task automatic read_back(int a);
        issue(REQ_READ, a[15:0], 8'($urandom), 8'($urandom), 1'($urandom));
    endtask

    task automatic next_match();
        issue(REQ_NEXT, 16'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
    endtask

    // stream kbytes[0..n-1], last flag on the final byte
    task automatic stream_key(int n);
        for (int i = 0; i < n; i++)
            issue(REQ_KEY, 16'($urandom), 8'($urandom), kbytes[i], i == n - 1);
    endtask

    task automatic load_db_key(int k);
        for (int i = 0; i < db_len[k]; i++) kbytes[i] = db_key[k][i];
    endtask

    // ------------------------------------------------------------------
    // Result checker: one strobed reply per cycle, no back-pressure
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_reply e;
        if (i_rst_n && o_valid) begin
            if (pending_replies.size() == 0) begin
                $error("reply with nothing expected: status %0d", o_status);
                mismatches++;
            end else begin
                e = pending_replies.pop_front();
                replies_seen++;
                status_count[o_status]++;
                if (o_status !== e.status) begin
                    $error("status: expected %0d, got %0d", e.status, o_status);
                    mismatches++;
                end
                if (o_rd_byte !== e.rd_byte) begin
                    $error("rd_byte: expected %0h, got %0h", e.rd_byte, o_rd_byte);
                    mismatches++;
                end
                if (o_value_addr !== e.value_addr) begin
                    $error("value_addr: expected %0h, got %0h", e.value_addr, o_value_addr);
                    mismatches++;
                end
                if (o_value_len !== e.value_len) begin
                    $error("value_len: expected %0h, got %0h", e.value_len, o_value_len);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Build records, hash tables and the header slots of the used buckets.
    task automatic test_load_image();
        logic [31:0] slot_h [32];
        logic [31:0] slot_p [32];
        int members [$];
        int tsize, s, dlen;
        gap_pct = 0;
        for (int k = 0; k < NKEYS; k++) begin
            db_len[k] = (k == 1) ? KMAX : $urandom_range(1, 8);
            for (int i = 0; i < db_len[k]; i++) db_key[k][i] = 8'($urandom);
        end
        // last key duplicates the first: a next request finds the second copy
        db_len[NKEYS - 1] = db_len[0];
        db_key[NKEYS - 1] = db_key[0];
        db_key[2][0] = 8'h00;
        db_key[3][0] = 8'hFF;
        heap_ptr = 2048;
        for (int k = 0; k < NKEYS; k++) begin
            load_db_key(k);
            db_hash[k] = djb_hash(db_len[k]);
            bucket_used[db_hash[k] % 256] = 1;
            dlen = $urandom_range(0, 4);
            rec_at[k] = heap_ptr;
            put32(heap_ptr, db_len[k]);
            put32(heap_ptr + 4, dlen);
            for (int i = 0; i < db_len[k]; i++) put8(heap_ptr + 8 + i, db_key[k][i]);
            for (int i = 0; i < dlen; i++) begin
                data_addrs.push_back(heap_ptr + 8 + db_len[k] + i);
                put8(heap_ptr + 8 + db_len[k] + i, 8'($urandom));
            end
            heap_ptr += 8 + db_len[k] + dlen;
        end
        gap_pct = 45;
        for (int b = 0; b < 256; b++) begin
            members = {};
            for (int k = 0; k < NKEYS; k++) if (db_hash[k] % 256 == b) members.push_back(k);
            if (members.size() != 0) begin
                tsize = 2 * members.size();
                for (int i = 0; i < tsize; i++) begin slot_h[i] = 0; slot_p[i] = 0; end
                foreach (members[m]) begin
                    s = (db_hash[members[m]] / 256) % tsize;
                    while (slot_p[s] != 0) s = (s + 1) % tsize;
                    slot_h[s] = db_hash[members[m]];
                    slot_p[s] = rec_at[members[m]];
                end
                for (int i = 0; i < tsize; i++) begin
                    put32(heap_ptr + 8 * i, slot_h[i]);
                    put32(heap_ptr + 8 * i + 4, slot_p[i]);
                end
                put32(b * 8, heap_ptr);
                put32(b * 8 + 4, tsize);
                heap_ptr += 8 * tsize;
            end
        end
    endtask

    task automatic test_found_keys();
        gap_pct = 0;
        for (int k = 0; k < NKEYS; k++) begin
            load_db_key(k);
            stream_key(db_len[k]);
        end
        read_back(rec_at[0]);
        read_back(rec_at[1] + 8);
    endtask

    // Duplicate key: found, next finds the copy, then the chain runs dry.
    task automatic test_next_chain();
        logic [31:0] h;
        gap_pct = 18;
        next_match();                 // nothing open after a fresh lookup run? check anyway
        load_db_key(0);
        stream_key(db_len[0]);
        next_match();
        next_match();
        next_match();                 // search closed by now
        kbytes[0] = 8'h5A;            // a key byte in the middle closes any search
        load_db_key(0);
        stream_key(db_len[0]);
        // two-byte key whose final byte lands in a loaded bucket
        kbytes[0] = 8'h11;
        kbytes[1] = 8'h00;
        h = djb_hash(2);
        while (!bucket_used[h % 256]) begin
            kbytes[1] = kbytes[1] + 8'd1;
            h = djb_hash(2);
        end
        issue(REQ_KEY, 16'($urandom), 8'($urandom), kbytes[0], 1'b0);
        next_match();
        issue(REQ_KEY, 16'($urandom), 8'($urandom), kbytes[1], 1'b1);
    endtask

    task automatic test_key_too_long();
        gap_pct = 0;
        for (int i = 0; i < 66; i++) kbytes[i] = 8'($urandom);
        stream_key(66);
        load_db_key(1);               // exactly the longest key still works
        stream_key(KMAX);
    endtask

    // Rewrite the bucket of a fresh probe key to reach every error path.
    task automatic test_bad_pointers();
        logic [31:0] h;
        int n, b, rec;
        gap_pct = 45;
        n = 3;
        do begin
            for (int i = 0; i < n; i++) kbytes[i] = 8'($urandom);
            h = djb_hash(n);
        end while (bucket_used[h % 256]);
        b = h % 256;
        bucket_used[b] = 1;
        // record holding the probe key with an oversized data length
        rec = heap_ptr;
        put32(rec, n);
        put32(rec + 4, 32'h0000_FFF0);
        for (int i = 0; i < n; i++) put8(rec + 8 + i, kbytes[i]);
        heap_ptr += 8 + n;
        put32(b * 8, 0);
        put32(b * 8 + 4, 0);
        stream_key(n);                // zero slot count
        // slot table past the end of the image
        put32(b * 8, 32'h0000_FFFC);
        put32(b * 8 + 4, 1);
        stream_key(n);
        // one-slot table; record pointer past the image
        put32(b * 8, heap_ptr);
        put32(heap_ptr, h);
        put32(heap_ptr + 4, 32'h0000_FFFC);
        stream_key(n);
        // record header fits but its key bytes run off the end
        put32(32'hFFF8, n);
        put32(32'hFFFC, 0);
        put32(heap_ptr + 4, 32'h0000_FFF8);
        stream_key(n);
        // data runs off the end
        put32(heap_ptr + 4, rec);
        stream_key(n);
        // empty slot
        put32(heap_ptr + 4, 0);
        stream_key(n);
        // every slot full of other hashes: probe wraps and gives up
        put32(heap_ptr, h ^ 32'h1);
        put32(heap_ptr + 4, rec);
        put32(heap_ptr + 8, h ^ 32'h2);
        put32(heap_ptr + 12, rec);
        put32(b * 8 + 4, 2);
        stream_key(n);
        next_match();
        read_back(16'hFFFF);
        heap_ptr += 16;
    endtask

    task automatic test_random_traffic();
        int sel, n, k, a;
        for (int it = 0; it < 40; it++) begin
            case (it / 10)
                0: gap_pct = 45;
                1: gap_pct = 0;
                2: gap_pct = 18;
                default: gap_pct = 0;
            endcase
            sel = $urandom_range(99);
            if (sel < 40) begin
                k = $urandom_range(NKEYS - 1);
                load_db_key(k);
                stream_key(db_len[k]);
                repeat ($urandom_range(0, 2)) next_match();
            end else if (sel < 55) begin
                n = ($urandom_range(9) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 6);
                // keep lookups inside buckets whose header was loaded
                do begin
                    for (int i = 0; i < n; i++) kbytes[i] = 8'($urandom);
                    if ($urandom_range(3) == 0)
                        kbytes[0] = db_key[$urandom_range(NKEYS - 1)][0];
                end while (!bucket_used[djb_hash(n) % 256]);
                stream_key(n);
            end else if (sel < 70) begin
                read_back(written_addrs[$urandom_range(written_addrs.size() - 1)]);
            end else if (sel < 85) begin
                // scratch area high in memory, or record payload bytes
                if ($urandom_range(1) || data_addrs.size() == 0)
                    a = $urandom_range(16'hC000, 16'hFFF7);
                else a = data_addrs[$urandom_range(data_addrs.size() - 1)];
                put8(a, 8'($urandom));
            end else begin
                next_match();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_req_type = REQ_WRITE;
        i_mem_addr = '0;
        i_wr_byte = '0;
        i_key_byte = '0;
        i_key_last = 1'b0;
        mismatches = 0;
        replies_seen = 0;
        hold_gap = 0;
        gap_pct = 0;
        key_fill = 0;
        hash_acc = HASH_INIT;
        tbl_base = 0; tbl_slots = 0; cur_slot = 0; slots_seen = 0;
        search_live = 0;
        target_hash = 0; target_len = 0;
        foreach (status_count[i]) status_count[i] = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_load_image();
        test_found_keys();
        test_next_chain();
        test_key_too_long();
        test_bad_pointers();
        test_random_traffic();

        if (hold_gap == 0) start <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        $display("Checked %0d replies: %0d found, %0d not found, %0d too long, %0d range.",
                 replies_seen, status_count[ST_FOUND], status_count[ST_NOTFOUND],
                 status_count[ST_TOOLONG], status_count[ST_RANGE]);
        if (mismatches == 0 && pending_replies.size() == 0)
            $display("** cdb_key_lookup_engine: PASSED **");
        else
            $display("** cdb_key_lookup_engine: FAILED **");
        $finish;
    end

    // watchdog
    initial begin
        #50_000_000;
        $display("Timeout with %0d replies outstanding", pending_replies.size());
        $display("** cdb_key_lookup_engine: FAILED **");
        $finish;
    end

endmodule
